[hdl/ils_pkg.sv]
// ils_pkg: shared types, codes and widths for the indexed list store
// no dependencies; imported by the interfaces, the cell, the scan unit and the top level
`default_nettype none

package ils_pkg;

  localparam int MODE_W = 2;
  localparam int POS_W  = 6;
  localparam int WORD_W = 32;
  localparam int ST_W   = 2;
  localparam int OCC_W  = 7;

  // default number of cells
  localparam int ILS_DEPTH_DEF = 64;
  // cells looked at per scan cycle, a power of two
  localparam int ILS_CHUNK     = 16;

  localparam logic [MODE_W-1:0] MODE_APPEND  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FIND    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_REPLACE = 2'd3;

  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE    = 2'd1;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd3;

  typedef logic [MODE_W-1:0] mode_t;
  typedef logic [WORD_W-1:0] word_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic  capture;
    logic  commit;
    mode_t mode;
  } cell_ctl_t;

endpackage

`default_nettype wire

[hdl/ils_in_if.sv]
// ils_in_if: request channel, valid/ready with mode, position and word
// depends on ils_pkg for the field widths
`default_nettype none

interface ils_in_if import ils_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic [POS_W-1:0]         position;
  logic signed [WORD_W-1:0] word;

  modport source (output valid, output mode, output position, output word, input ready);
  modport sink   (input valid, input mode, input position, input word, output ready);
endinterface

`default_nettype wire

[hdl/ils_out_if.sv]
// ils_out_if: result channel, valid/ready with status, answer and occupancy
// depends on ils_pkg for the field widths
`default_nettype none

interface ils_out_if import ils_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [ST_W-1:0]          status;
  logic signed [WORD_W-1:0] answer;
  logic [OCC_W-1:0]         occupancy;

  modport source (output valid, output status, output answer, output occupancy, input ready);
  modport sink   (input valid, input status, input answer, input occupancy, output ready);
endinterface

`default_nettype wire

[hdl/ils_cell.sv]
// ils_cell: one list entry; compares against the request and shifts down on remove
// depends on ils_pkg (cell_ctl_t, mode codes)
`default_nettype none

module ils_cell import ils_pkg::*; #(
  parameter int IDX   = 0,
  parameter int CNT_W = 7
) (
  input  wire logic             clk,
  input  wire cell_ctl_t        ctl,
  input  wire logic [CNT_W-1:0] count,
  input  wire logic [CNT_W-1:0] pos,
  input  wire word_t            word,
  input  wire word_t            right_data,
  output      word_t            data,
  output      logic             hit
);

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  word_t data_r;
  logic  hit_r;
  logic  valid;
  logic  at_pos;
  logic  at_end;
  logic  hit_nxt;

  assign valid  = (MY_IDX < count);
  assign at_pos = (MY_IDX == pos);
  assign at_end = (MY_IDX == count);

  always_comb begin
    if (ctl.mode == MODE_FIND) begin
      hit_nxt = valid && (data_r == word);
    end else begin
      hit_nxt = at_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      hit_r <= hit_nxt;
    end
    if (ctl.commit) begin
      unique case (ctl.mode)
        MODE_APPEND: begin
          if (at_end) data_r <= word;
        end
        MODE_REMOVE: begin
          // take the right-hand neighbour's word from the removed slot upwards
          if (MY_IDX >= pos) data_r <= right_data;
        end
        MODE_REPLACE: begin
          if (at_pos) data_r <= word;
        end
        default: begin
        end
      endcase
    end
  end

  assign data = data_r;
  assign hit  = hit_r;

endmodule

`default_nettype wire

[hdl/ils_scan.sv]
// ils_scan: finds the lowest flagged cell, one chunk of cells per cycle
// depends on ils_pkg (word_t, ILS_CHUNK)
`default_nettype none

module ils_scan import ils_pkg::*; #(
  parameter int DEPTH = ILS_DEPTH_DEF,
  parameter int CHUNK = ILS_CHUNK
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [DEPTH-1:0]         hits,
  input  wire word_t                    words [DEPTH],
  output      logic                     done,
  output      logic                     found,
  output      logic [$clog2(DEPTH)-1:0] idx,
  output      word_t                    word
);

  localparam int NCH   = (DEPTH + CHUNK - 1) / CHUNK;
  localparam int PAD   = NCH * CHUNK;
  localparam int CH_W  = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int K_W   = $clog2(CHUNK);
  localparam int PW    = $clog2(PAD);
  localparam int IDX_W = $clog2(DEPTH);

  logic [PAD-1:0]   hits_pad;
  word_t            words_pad [PAD];
  logic [CH_W-1:0]  ch_r;
  logic             busy_r;
  logic             done_r;
  logic             found_r;
  logic [IDX_W-1:0] idx_r;
  word_t            word_r;
  logic [CHUNK-1:0] slice;
  logic [K_W-1:0]   k;
  logic             any;
  logic             last;
  logic [PW-1:0]    sel_idx;

  assign hits_pad = PAD'(hits);

  for (genvar g = 0; g < PAD; g++) begin : g_pad
    if (g < DEPTH) begin : g_real
      assign words_pad[g] = words[g];
    end else begin : g_fill
      assign words_pad[g] = '0;
    end
  end

  assign slice = hits_pad[ch_r*CHUNK +: CHUNK];

  // lowest set flag within the chunk
  always_comb begin
    any = 1'b0;
    k   = '0;
    for (int j = CHUNK - 1; j >= 0; j--) begin
      if (slice[j]) begin
        any = 1'b1;
        k   = K_W'(j);
      end
    end
  end

  assign last    = (ch_r == CH_W'(NCH - 1));
  assign sel_idx = PW'({ch_r, k});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ch_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        ch_r   <= '0;
      end else if (busy_r) begin
        if (any || last) begin
          busy_r  <= 1'b0;
          done_r  <= 1'b1;
          found_r <= any;
          idx_r   <= IDX_W'(sel_idx);
          word_r  <= words_pad[sel_idx];
        end else begin
          ch_r <= ch_r + 1'b1;
        end
      end
    end
  end

  assign done  = done_r;
  assign found = found_r;
  assign idx   = idx_r;
  assign word  = word_r;

endmodule

`default_nettype wire

[hdl/indexed_list_store_unit.sv]
// indexed_list_store_unit: bounded ordered word list built from a chain of cells
// depends on ils_pkg, ils_in_if, ils_out_if, ils_cell and ils_scan
//
//   channel  | dir | transfer carries
//   in_ch    | in  | mode, position, word
//   out_ch   | out | status, answer, occupancy
//
// append, remove and any rejected request pass from transfer through the capture and
// final steps to the result; find and an in-range replace add the scan between them,
// one chunk of 16 cells a cycle through the shared scan unit
// one request in flight; the next is taken while a result waits in the output
// register, and that request holds in its last step until the result is taken
// reset empties the list at once; entry words are left as they were
`default_nettype none

module indexed_list_store_unit import ils_pkg::*; #(
  parameter int DEPTH = ILS_DEPTH_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  ils_in_if.sink   in_ch,
  ils_out_if.source out_ch
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CW    = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CAP  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  mode_t            req_mode_r;
  logic [POS_W-1:0] req_pos_r;
  word_t            req_word_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [ST_W-1:0]  status_r;
  word_t            answer_r;

  logic             out_valid_r;
  logic [ST_W-1:0]  out_status_r;
  word_t            out_answer_r;
  logic [OCC_W-1:0] out_occ_r;

  logic             accept;
  logic             in_range;
  logic             full;
  logic             out_free;
  logic             finish;
  logic             commit;
  logic             scan_start;
  cell_ctl_t        ctl;

  word_t            cell_data [DEPTH];
  logic [DEPTH-1:0] cell_hit;
  logic             scan_done;
  logic             scan_found;
  logic [IDX_W-1:0] scan_idx;
  word_t            scan_word;

  assign accept   = in_ch.valid && in_ch.ready;
  assign in_range = (CW'(req_pos_r) < CW'(count_r));
  assign full     = (count_r == CNT_W'(DEPTH));
  assign out_free = !out_valid_r || out_ch.ready;
  assign finish   = (state_r == S_FIN) && out_free;
  assign commit   = finish && (status_r == ST_OK) && (req_mode_r != MODE_FIND);
  assign scan_start = (state_r == S_CAP) &&
                      ((req_mode_r == MODE_FIND) || ((req_mode_r == MODE_REPLACE) && in_range));

  assign ctl.capture = (state_r == S_CAP);
  assign ctl.commit  = commit;
  assign ctl.mode    = req_mode_r;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    word_t right;
    if (g == DEPTH - 1) begin : g_end
      assign right = cell_data[g];
    end else begin : g_mid
      assign right = cell_data[g+1];
    end
    ils_cell #(
      .IDX   (g),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .count      (count_r),
      .pos        (CNT_W'(req_pos_r)),
      .word       (req_word_r),
      .right_data (right),
      .data       (cell_data[g]),
      .hit        (cell_hit[g])
    );
  end

  ils_scan #(
    .DEPTH (DEPTH),
    .CHUNK (ILS_CHUNK)
  ) u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .start (scan_start),
    .hits  (cell_hit),
    .words (cell_data),
    .done  (scan_done),
    .found (scan_found),
    .idx   (scan_idx),
    .word  (scan_word)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept)    state_nxt = S_CAP;
      S_CAP:  state_nxt = scan_start ? S_SCAN : S_FIN;
      S_SCAN: if (scan_done) state_nxt = S_FIN;
      S_FIN:  if (out_free)  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (commit) begin
      unique case (req_mode_r)
        MODE_APPEND: count_nxt = count_r + 1'b1;
        MODE_REMOVE: count_nxt = count_r - 1'b1;
        default:     count_nxt = count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request, status and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      req_mode_r <= in_ch.mode;
      req_pos_r  <= in_ch.position;
      req_word_r <= in_ch.word;
    end
    if (state_r == S_CAP) begin
      answer_r <= '0;
      unique case (req_mode_r) inside
        MODE_APPEND:               status_r <= full ? ST_FULL : ST_OK;
        MODE_REMOVE, MODE_REPLACE: status_r <= in_range ? ST_OK : ST_RANGE;
        default:                   status_r <= ST_NOTFOUND;
      endcase
    end else if ((state_r == S_SCAN) && scan_done) begin
      status_r <= scan_found ? ST_OK : ST_NOTFOUND;
      if (scan_found) begin
        answer_r <= (req_mode_r == MODE_FIND) ? WORD_W'(scan_idx) : scan_word;
      end
    end
    if (finish) begin
      out_status_r <= status_r;
      out_answer_r <= answer_r;
      out_occ_r    <= OCC_W'(count_nxt);
    end
  end

  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.answer    = out_answer_r;
  assign out_ch.occupancy = out_occ_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("occupancy beyond depth");

  a_accept_cap: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_CAP)
    else $error("transfer not followed by capture");

  a_scan_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    scan_done |-> state_r == S_SCAN)
    else $error("scan finished outside scan step");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result loaded outside final step");

  a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && req_mode_r == MODE_APPEND) |=> count_r == $past(count_r) + 1'b1)
    else $error("append did not grow the list");

endmodule

`default_nettype wire
